[sv/sle_pkg.sv]
// sle_pkg: shared constants, scan code map and command/status types for the
// scan code line editor; used by the controller, datapath and top level
package sle_pkg;

   localparam int LINE_LIMIT_DEFAULT = 40;

   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;

   localparam logic [6:0] CH_BACKSPACE = 7'd8;
   localparam logic [6:0] CH_ENTER     = 7'd10;
   localparam logic [6:0] CASE_OFFSET  = 7'd32;

   // result kinds
   localparam logic [1:0] KIND_ECHO      = 2'd0;
   localparam logic [1:0] KIND_ERASE     = 2'd1;
   localparam logic [1:0] KIND_LINE_CHAR = 2'd2;
   localparam logic [1:0] KIND_LINE_END  = 2'd3;

   // decoded request classes
   localparam logic [2:0] CLS_NONE      = 3'd0;
   localparam logic [2:0] CLS_SHIFT_SET = 3'd1;
   localparam logic [2:0] CLS_SHIFT_CLR = 3'd2;
   localparam logic [2:0] CLS_ENTER     = 3'd3;
   localparam logic [2:0] CLS_ERASE     = 3'd4;
   localparam logic [2:0] CLS_CHAR      = 3'd5;

   // output character sources
   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_DEC  = 2'd1;
   localparam logic [1:0] SRC_RAM  = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       shift_set;
      logic       shift_clr;
      logic       len_inc;
      logic       len_dec;
      logic       len_clr;
      logic       ram_we;
      logic       rd_start;
      logic       rd_next;
      logic       out_load;
      logic [1:0] out_kind;
      logic [1:0] out_src;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] cls;
      logic       len_zero;
      logic       len_full;
      logic       ptr_at_len;
      logic       out_free;
   } status_type;

   function automatic logic [6:0] key_char(input logic [6:0] code);
      logic [6:0] c;
      c = 7'h00;
      unique case (code)
         7'h02: c = 7'h31;
         7'h03: c = 7'h32;
         7'h04: c = 7'h33;
         7'h05: c = 7'h34;
         7'h06: c = 7'h35;
         7'h07: c = 7'h36;
         7'h08: c = 7'h37;
         7'h09: c = 7'h38;
         7'h0A: c = 7'h39;
         7'h0B: c = 7'h30;
         7'h0C: c = 7'h2D;
         7'h0D: c = 7'h3D;
         7'h0E: c = CH_BACKSPACE;
         7'h10: c = 7'h71;
         7'h11: c = 7'h77;
         7'h12: c = 7'h65;
         7'h13: c = 7'h72;
         7'h14: c = 7'h74;
         7'h15: c = 7'h79;
         7'h16: c = 7'h75;
         7'h17: c = 7'h69;
         7'h18: c = 7'h6F;
         7'h19: c = 7'h70;
         7'h1C: c = CH_ENTER;
         7'h1E: c = 7'h61;
         7'h1F: c = 7'h73;
         7'h20: c = 7'h64;
         7'h21: c = 7'h66;
         7'h22: c = 7'h67;
         7'h23: c = 7'h68;
         7'h24: c = 7'h6A;
         7'h25: c = 7'h6B;
         7'h26: c = 7'h6C;
         7'h2C: c = 7'h7A;
         7'h2D: c = 7'h78;
         7'h2E: c = 7'h63;
         7'h2F: c = 7'h76;
         7'h30: c = 7'h62;
         7'h31: c = 7'h6E;
         7'h32: c = 7'h6D;
         7'h35: c = 7'h2F;
         7'h37: c = 7'h2A;
         7'h39: c = 7'h20;
         7'h4A: c = 7'h2D;
         7'h4E: c = 7'h2B;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_lower(input logic [6:0] c);
      return (c >= 7'h61) && (c <= 7'h7A);
   endfunction

   function automatic logic [6:0] shifted(input logic [6:0] c);
      logic [6:0] r;
      r = c;
      if (is_lower(c)) begin
         r = c - CASE_OFFSET;
      end else if (c == 7'h38) begin
         r = 7'h2A;
      end else if (c == 7'h3D) begin
         r = 7'h2B;
      end
      return r;
   endfunction

   function automatic logic allowed(input logic [6:0] c);
      return is_lower(c) || ((c >= 7'h41) && (c <= 7'h5A))
         || ((c >= 7'h30) && (c <= 7'h39))
         || (c == 7'h20) || (c == 7'h2B) || (c == 7'h2D) || (c == 7'h2A)
         || (c == 7'h2F);
   endfunction

endpackage

[sv/sle_ram.sv]
// sle_ram: generic single write port, single read port ram with registered
// read data; no package dependency
module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sle_datapath.sv]
// sle_datapath: scan code decode, shift flag, line length, read pointer,
// line store and result register; depends on sle_pkg and sle_ram
module sle_datapath #(
   parameter int LINE_LIMIT = sle_pkg::LINE_LIMIT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          scan_code,
   input  sle_pkg::cmd_type    cmd,
   output sle_pkg::status_type status,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [1:0]          out_kind,
   output logic [6:0]          out_char_code,
   output logic                out_last
);
   import sle_pkg::*;

   localparam int LenW  = $clog2(LINE_LIMIT + 1);
   localparam int AddrW = (LINE_LIMIT > 1) ? $clog2(LINE_LIMIT) : 1;

   logic [7:0]      code_ff, code_in;
   logic            shift_ff, shift_in;
   logic [LenW-1:0] len_ff, len_in;
   logic [LenW-1:0] ptr_ff, ptr_in;
   logic            out_valid_ff, out_valid_in;
   logic [1:0]      out_kind_ff, out_kind_in;
   logic [6:0]      out_char_ff, out_char_in;
   logic            out_last_ff, out_last_in;

   logic [6:0]       map_char, dec_char, rd_data;
   logic [2:0]       cls;
   logic [AddrW-1:0] rd_addr;
   logic             rd_en;

   // decode the captured code under the current shift state
   always_comb begin
      map_char = key_char(code_ff[6:0]);
      dec_char = shift_ff ? shifted(map_char) : map_char;
      if ((code_ff == SC_LSHIFT_MAKE) || (code_ff == SC_RSHIFT_MAKE)) begin
         cls = CLS_SHIFT_SET;
      end else if ((code_ff == SC_LSHIFT_BREAK) || (code_ff == SC_RSHIFT_BREAK)) begin
         cls = CLS_SHIFT_CLR;
      end else if (code_ff[7] || (map_char == 7'h00)) begin
         cls = CLS_NONE;
      end else if (dec_char == CH_ENTER) begin
         cls = CLS_ENTER;
      end else if (dec_char == CH_BACKSPACE) begin
         cls = CLS_ERASE;
      end else if (allowed(dec_char)) begin
         cls = CLS_CHAR;
      end else begin
         cls = CLS_NONE;
      end
   end

   assign rd_en   = cmd.rd_start || cmd.rd_next;
   assign rd_addr = cmd.rd_start ? '0 : ptr_ff[AddrW-1:0];

   sle_ram #(
      .WIDTH(7),
      .DEPTH(LINE_LIMIT)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (cmd.ram_we),
      .wr_addr(len_ff[AddrW-1:0]),
      .wr_data(dec_char),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      code_in = cmd.capture ? scan_code : code_ff;

      shift_in = shift_ff;
      if (cmd.shift_set) begin
         shift_in = 1'b1;
      end else if (cmd.shift_clr) begin
         shift_in = 1'b0;
      end

      len_in = len_ff;
      if (cmd.len_clr) begin
         len_in = '0;
      end else if (cmd.len_inc) begin
         len_in = len_ff + LenW'(1);
      end else if (cmd.len_dec) begin
         len_in = len_ff - LenW'(1);
      end

      ptr_in = ptr_ff;
      if (cmd.rd_start) begin
         ptr_in = LenW'(1);
      end else if (cmd.rd_next) begin
         ptr_in = ptr_ff + LenW'(1);
      end

      out_valid_in = out_valid_ff && !out_ready;
      out_kind_in  = out_kind_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_kind_in  = cmd.out_kind;
         out_last_in  = cmd.out_last;
         case (cmd.out_src)
            SRC_DEC: out_char_in = dec_char;
            SRC_RAM: out_char_in = rd_data;
            default: out_char_in = 7'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 1'b0;
         len_ff       <= '0;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      out_kind_ff <= out_kind_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign status.cls        = cls;
   assign status.len_zero   = (len_ff == '0);
   assign status.len_full   = (len_ff >= LenW'(LINE_LIMIT));
   assign status.ptr_at_len = (ptr_ff == len_ff);
   assign status.out_free   = !out_valid_ff || out_ready;

   assign out_valid     = out_valid_ff;
   assign out_kind      = out_kind_ff;
   assign out_char_code = out_char_ff;
   assign out_last      = out_last_ff;

endmodule

[sv/sle_ctrl.sv]
// sle_ctrl: controller state machine for the line editor; turns datapath
// status into commands; depends on sle_pkg
module sle_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sle_pkg::status_type status,
   output sle_pkg::cmd_type    cmd
);
   import sle_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_END    = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.out_src = SRC_ZERO;
      req_ready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (status.cls)
               CLS_SHIFT_SET: cmd.shift_set = 1'b1;
               CLS_SHIFT_CLR: cmd.shift_clr = 1'b1;
               CLS_ERASE: begin
                  if (!status.len_zero) begin
                     if (status.out_free) begin
                        cmd.len_dec  = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_ERASE;
                        cmd.out_last = 1'b1;
                     end else begin
                        state_in = S_DECODE;
                     end
                  end
               end
               CLS_CHAR: begin
                  if (!status.len_full) begin
                     if (status.out_free) begin
                        cmd.ram_we   = 1'b1;
                        cmd.len_inc  = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_ECHO;
                        cmd.out_src  = SRC_DEC;
                        cmd.out_last = 1'b1;
                     end else begin
                        state_in = S_DECODE;
                     end
                  end
               end
               CLS_ENTER: begin
                  if (!status.len_zero) begin
                     cmd.rd_start = 1'b1;
                     state_in     = S_READ;
                  end else begin
                     state_in = S_END;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_READ: begin
            // read data waits in the ram output register until it is loaded
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_LINE_CHAR;
               cmd.out_src  = SRC_RAM;
               if (status.ptr_at_len) begin
                  state_in = S_END;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         S_END: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_LINE_END;
               cmd.out_last = 1'b1;
               cmd.len_clr  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/scancode_line_editor.sv]
// scancode_line_editor: set 1 scan code to ascii one-line editor, top level
// joins sle_ctrl and sle_datapath; depends on sle_pkg
//
//   channel  dir  payload                                     handshake
//   req_     in   tdata[7:0] scan_code                         tvalid/tready
//   rsp_     out  tdata[1:0] kind, [8:2] char_code; tlast last tvalid/tready
//
// a scan code is accepted in idle and decoded in the decode state; a result, when there is
// one, lands in the output register and the next request is taken meanwhile
// enter streams the stored line from the line ram at one character per
// cycle while rsp_tready does not stall it, then the line end
// a stalled rsp_tready holds the controller before it loads the next result
// reset clears shift, line length and the output valid; the ram is not cleared
module scancode_line_editor #(
   parameter int LINE_LIMIT = sle_pkg::LINE_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] kind, [8:2] char_code, [15:9] zero
   output logic        rsp_tlast
);
   import sle_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [1:0] out_kind;
   logic [6:0] out_char_code;

   sle_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   sle_datapath #(
      .LINE_LIMIT(LINE_LIMIT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .scan_code    (req_tdata),
      .cmd          (cmd),
      .status       (status),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_kind     (out_kind),
      .out_char_code(out_char_code),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {7'h00, out_char_code, out_kind};

   // never load a result over one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded while output register busy");

   // a character is only stored into a line with room left
   assert property (@(posedge clock) disable iff (reset)
      cmd.ram_we |-> !status.len_full)
      else $error("line store written past the limit");

   // erase only on a non-empty line
   assert property (@(posedge clock) disable iff (reset)
      cmd.len_dec |-> !status.len_zero)
      else $error("line length decremented below zero");

   // an accepted request is decoded before another is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted during decode");

endmodule
